// ----- rtl/htfd_pkg.sv -----
package htfd_pkg;

  typedef logic [2:0] pos_t;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam pos_t POS_TEMP_HI  = 3'd0;
  localparam pos_t POS_TEMP_LO  = 3'd1;
  localparam pos_t POS_TEMP_CRC = 3'd2;
  localparam pos_t POS_HUM_HI   = 3'd3;
  localparam pos_t POS_HUM_LO   = 3'd4;
  localparam pos_t POS_HUM_CRC  = 3'd5;

  localparam int TEMP_SPAN   = 17500;
  localparam int TEMP_OFFSET = 4500;
  localparam int HUM_SPAN    = 10000;
  localparam int FULL_SCALE  = 65535;

  typedef struct packed {
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
    logic        temperature_check_ok;
    logic        humidity_check_ok;
  } frame_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
  } scaled_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/htfd_if.sv -----
interface htfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source(output valid, output data_byte, output frame_start, input ready);
  modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_result_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [15:0]        temperature_raw;
  logic [15:0]        humidity_raw;
  logic               temperature_check_ok;
  logic               humidity_check_ok;
  logic               reading_valid;

  modport source(output valid, output temperature_centi, output humidity_centi,
                 output temperature_raw, output humidity_raw,
                 output temperature_check_ok, output humidity_check_ok,
                 output reading_valid, input ready);
  modport sink(input valid, input temperature_centi, input humidity_centi,
               input temperature_raw, input humidity_raw,
               input temperature_check_ok, input humidity_check_ok,
               input reading_valid, output ready);
endinterface

// ----- rtl/htfd_scale.sv -----
module htfd_scale (
  input  htfd_pkg::frame_t  frame,
  output htfd_pkg::scaled_t scaled
);

  logic [30:0] temp_prod;
  logic [14:0] temp_q0;
  logic [16:0] temp_rem;
  logic [14:0] temp_q;
  logic [15:0] temp_shifted;
  logic [29:0] hum_prod;
  logic [13:0] hum_q0;
  logic [16:0] hum_rem;
  logic [13:0] hum_q;

  // x / 65535: quotient estimate x >> 16, remainder (x mod 2^16) + estimate,
  // one correction since the remainder stays below twice the divisor
  assign temp_prod = 31'(htfd_pkg::TEMP_SPAN) * {15'd0, frame.temperature_raw};
  assign temp_q0   = temp_prod[30:16];
  assign temp_rem  = {1'b0, temp_prod[15:0]} + {2'b00, temp_q0};
  assign temp_q    = temp_q0 + 15'(temp_rem >= 17'(htfd_pkg::FULL_SCALE));
  assign temp_shifted = {1'b0, temp_q} - 16'(htfd_pkg::TEMP_OFFSET);

  assign hum_prod = 30'(htfd_pkg::HUM_SPAN) * {14'd0, frame.humidity_raw};
  assign hum_q0   = hum_prod[29:16];
  assign hum_rem  = {1'b0, hum_prod[15:0]} + {3'b000, hum_q0};
  assign hum_q    = hum_q0 + 14'(hum_rem >= 17'(htfd_pkg::FULL_SCALE));

  assign scaled.temperature_centi = signed'(temp_shifted[14:0]);
  assign scaled.humidity_centi    = hum_q;

endmodule

// ----- rtl/humidity_temp_frame_decoder_top.sv -----
// Decodes six-byte humidity and temperature frames (temperature word, its
// CRC-8, humidity word, its CRC-8; polynomial 0x31, start value 0xFF). One
// byte is taken per clock; rx.ready is low only while both result stages are
// full and the result side is stalled. After a frame's sixth byte is taken,
// its result moves through the frame register into the output register,
// with both raw words, the two check flags, reading_valid, and the readings
// in hundredths (floor(17500*raw/65535)-4500 and floor(10000*raw/65535)).
// The rate of one byte per cycle is set by the combinational byte CRC step;
// the scaling multiply and its constant-division correction sit in the
// stage between the frame register and the output register. frame_start
// restarts the frame at the byte that carries it.
module humidity_temp_frame_decoder_top (
  input logic            clk,
  input logic            rst,
  htfd_rx_if.sink        rx,
  htfd_result_if.source  result
);

  htfd_pkg::pos_t    byte_position;
  htfd_pkg::pos_t    byte_position_next;
  htfd_pkg::pos_t    pos_eff;
  logic [7:0]        running_check;
  logic [7:0]        running_check_next;
  logic [7:0]        check_eff;
  logic [15:0]       temperature_word;
  logic [7:0]        humidity_high_byte;
  logic [7:0]        humidity_low_byte;
  logic              temperature_pass;
  logic              rx_accept;
  logic              last_accept;
  logic              check_match;
  logic              frame_valid;
  htfd_pkg::frame_t  frame;
  htfd_pkg::frame_t  frame_in;
  htfd_pkg::scaled_t scaled;
  logic              out_valid;
  logic              out_move;
  logic              frame_move;

  assign out_move   = !out_valid || result.ready;
  assign frame_move = !frame_valid || out_move;
  assign rx.ready   = frame_move;
  assign rx_accept  = rx.valid && rx.ready;

  always_comb begin
    if (rx.frame_start || byte_position > htfd_pkg::POS_HUM_CRC) begin
      pos_eff   = htfd_pkg::POS_TEMP_HI;
      check_eff = htfd_pkg::CRC_INIT;
    end else begin
      pos_eff   = byte_position;
      check_eff = running_check;
    end
  end

  assign check_match = (check_eff == rx.data_byte);
  assign last_accept = rx_accept && (pos_eff == htfd_pkg::POS_HUM_CRC);

  always_comb begin
    unique case (pos_eff)
      htfd_pkg::POS_TEMP_HI: begin
        running_check_next = htfd_pkg::crc_byte(htfd_pkg::CRC_INIT, rx.data_byte);
        byte_position_next = htfd_pkg::POS_TEMP_LO;
      end
      htfd_pkg::POS_TEMP_LO: begin
        running_check_next = htfd_pkg::crc_byte(check_eff, rx.data_byte);
        byte_position_next = htfd_pkg::POS_TEMP_CRC;
      end
      htfd_pkg::POS_TEMP_CRC: begin
        running_check_next = htfd_pkg::CRC_INIT;
        byte_position_next = htfd_pkg::POS_HUM_HI;
      end
      htfd_pkg::POS_HUM_HI: begin
        running_check_next = htfd_pkg::crc_byte(htfd_pkg::CRC_INIT, rx.data_byte);
        byte_position_next = htfd_pkg::POS_HUM_LO;
      end
      htfd_pkg::POS_HUM_LO: begin
        running_check_next = htfd_pkg::crc_byte(check_eff, rx.data_byte);
        byte_position_next = htfd_pkg::POS_HUM_CRC;
      end
      default: begin
        running_check_next = htfd_pkg::CRC_INIT;
        byte_position_next = htfd_pkg::POS_TEMP_HI;
      end
    endcase
  end

  assign frame_in.temperature_raw      = temperature_word;
  assign frame_in.humidity_raw         = {humidity_high_byte, humidity_low_byte};
  assign frame_in.temperature_check_ok = temperature_pass;
  assign frame_in.humidity_check_ok    = check_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= htfd_pkg::POS_TEMP_HI;
      running_check <= htfd_pkg::CRC_INIT;
      frame_valid   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (rx_accept) begin
        byte_position <= byte_position_next;
        running_check <= running_check_next;
      end
      if (frame_move) begin
        frame_valid <= last_accept;
      end
      if (out_move) begin
        out_valid <= frame_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept) begin
      unique case (pos_eff)
        htfd_pkg::POS_TEMP_HI:  temperature_word[15:8] <= rx.data_byte;
        htfd_pkg::POS_TEMP_LO:  temperature_word[7:0]  <= rx.data_byte;
        htfd_pkg::POS_TEMP_CRC: temperature_pass       <= check_match;
        htfd_pkg::POS_HUM_HI:   humidity_high_byte     <= rx.data_byte;
        htfd_pkg::POS_HUM_LO:   humidity_low_byte      <= rx.data_byte;
        default: begin
        end
      endcase
    end
    if (last_accept) begin
      frame <= frame_in;
    end
    if (out_move && frame_valid) begin
      result.temperature_centi    <= scaled.temperature_centi;
      result.humidity_centi       <= scaled.humidity_centi;
      result.temperature_raw      <= frame.temperature_raw;
      result.humidity_raw         <= frame.humidity_raw;
      result.temperature_check_ok <= frame.temperature_check_ok;
      result.humidity_check_ok    <= frame.humidity_check_ok;
      result.reading_valid        <= frame.temperature_check_ok && frame.humidity_check_ok;
    end
  end

  assign result.valid = out_valid;

  htfd_scale u_scale (
    .frame  (frame),
    .scaled (scaled)
  );

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= htfd_pkg::POS_HUM_CRC)
    else $error("byte position out of range");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (rx_accept && rx.frame_start) |=> (byte_position == htfd_pkg::POS_TEMP_LO))
    else $error("frame start did not restart the frame");

  a_last_loads_frame: assert property (@(posedge clk) disable iff (rst)
    last_accept |=> frame_valid)
    else $error("sixth byte did not load the frame stage");

  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.reading_valid ==
                   (result.temperature_check_ok && result.humidity_check_ok)))
    else $error("reading_valid disagrees with check flags");
`endif

endmodule

// ----- bench/humidity_temp_frame_decoder_top_tb.sv -----
`timescale 1ns / 100ps

module humidity_temp_frame_decoder_top_tb;

  typedef struct {
    logic [7:0] data_byte;
    logic       frame_start;
  } rx_byte_t;

  typedef struct {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [15:0]        temperature_raw;
    logic [15:0]        humidity_raw;
    logic               temperature_check_ok;
    logic               humidity_check_ok;
    logic               reading_valid;
  } reading_t;

  localparam int NUM_BYTES      = 1850;
  localparam int CALM_TAIL      = 250;
  localparam int HOLD_AT        = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 10;

  logic clk;
  logic rst;

  htfd_rx_if     rx_if ();
  htfd_result_if res_if ();

  humidity_temp_frame_decoder_top DUT (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if)
  );

  rx_byte_t   byte_queue[$];
  reading_t   reading_queue[$];
  int         mismatches = 0;
  int         readings_seen = 0;
  int         idle_cycles = 0;

  // decoder state mirror
  htfd_pkg::pos_t frame_pos = htfd_pkg::POS_TEMP_HI;
  logic [7:0]     frame_crc = htfd_pkg::CRC_INIT;
  logic [15:0]    temp_word = '0;
  logic [15:0]    hum_word = '0;
  logic           temp_ok = 1'b0;

  int tx_gap = 0;
  int tx_stretch = 0;
  bit tx_quiet = 1'b0;
  int rx_gap = 0;
  int rx_stretch = 0;
  bit rx_quiet = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output reading_t r);
    int tq;
    int hq;
    logic hum_ok;
    r = '{default: '0};
    if (start) begin
      frame_pos = htfd_pkg::POS_TEMP_HI;
      frame_crc = htfd_pkg::CRC_INIT;
    end
    if (frame_pos > htfd_pkg::POS_HUM_CRC) begin
      frame_pos = htfd_pkg::POS_TEMP_HI;
      frame_crc = htfd_pkg::CRC_INIT;
    end
    case (frame_pos)
      htfd_pkg::POS_TEMP_HI: begin
        frame_crc = crc8_step(htfd_pkg::CRC_INIT, b);
        temp_word = {b, 8'h00};
      end
      htfd_pkg::POS_TEMP_LO: begin
        frame_crc = crc8_step(frame_crc, b);
        temp_word[7:0] = b;
      end
      htfd_pkg::POS_TEMP_CRC: begin
        temp_ok = (frame_crc == b);
        frame_crc = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_HUM_HI: begin
        frame_crc = crc8_step(htfd_pkg::CRC_INIT, b);
        hum_word[15:8] = b;
      end
      htfd_pkg::POS_HUM_LO: begin
        frame_crc = crc8_step(frame_crc, b);
        hum_word[7:0] = b;
      end
      default: begin
        hum_ok = (frame_crc == b);
        tq = (htfd_pkg::TEMP_SPAN * int'(temp_word)) / htfd_pkg::FULL_SCALE;
        hq = (htfd_pkg::HUM_SPAN * int'(hum_word)) / htfd_pkg::FULL_SCALE;
        r.temperature_centi    = 15'(tq - htfd_pkg::TEMP_OFFSET);
        r.humidity_centi       = 14'(hq);
        r.temperature_raw      = temp_word;
        r.humidity_raw         = hum_word;
        r.temperature_check_ok = temp_ok;
        r.humidity_check_ok    = hum_ok;
        r.reading_valid        = temp_ok & hum_ok;
        frame_pos = htfd_pkg::POS_TEMP_HI;
        frame_crc = htfd_pkg::CRC_INIT;
        return 1'b1;
      end
    endcase
    frame_pos = frame_pos + 3'd1;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
    mismatches++;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic start);
    rx_byte_t it;
    it.data_byte = b;
    it.frame_start = start;
    byte_queue.push_back(it);
  endtask

  task automatic add_frame(input logic [15:0] traw, input logic [15:0] hraw,
                           input logic start, input bit temp_bad, input bit hum_bad);
    logic [7:0] tcrc;
    logic [7:0] hcrc;
    tcrc = crc8_step(crc8_step(htfd_pkg::CRC_INIT, traw[15:8]), traw[7:0]);
    hcrc = crc8_step(crc8_step(htfd_pkg::CRC_INIT, hraw[15:8]), hraw[7:0]);
    if (temp_bad) tcrc ^= 8'($urandom_range(1, 255));
    if (hum_bad) hcrc ^= 8'($urandom_range(1, 255));
    add_byte(traw[15:8], start);
    add_byte(traw[7:0], 1'b0);
    add_byte(tcrc, 1'b0);
    add_byte(hraw[15:8], 1'b0);
    add_byte(hraw[7:0], 1'b0);
    add_byte(hcrc, 1'b0);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    int pick;
    int n;
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.data_byte = '0;
    rx_if.frame_start = 1'b0;
    res_if.ready = 1'b0;

    // extremes, good checks
    add_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    // next frame with no start mark, bad temperature check
    add_frame(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b0);
    // partial frame dropped by a start mark, then bad humidity check
    add_byte(8'hBE, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'h92, 1'b0);
    add_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);

    while (byte_queue.size() < NUM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        add_frame(rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
      end else if (pick < 9) begin
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
          add_byte(8'($urandom), (k == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
        end
        add_frame(rand_word(), rand_word(), 1'b1, 1'b0, 1'b0);
      end else begin
        n = $urandom_range(1, 9);
        for (int k = 0; k < n; k++) begin
          add_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
        add_frame(rand_word(), rand_word(), 1'b1, 1'b0, 1'b0);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || rx_if.valid) @(posedge clk);
    while (reading_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("humidity_temp_frame_decoder_top_tb: PASS");
    end else begin
      $display("humidity_temp_frame_decoder_top_tb: FAIL");
    end
    $finish;
  end

  // byte driver
  always @(posedge clk) begin
    reading_t r;
    rx_byte_t it;
    if (rst) begin
      rx_if.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        if (decode_byte(rx_if.data_byte, rx_if.frame_start, r)) reading_queue.push_back(r);
      end
      if (tx_stretch == 0) begin
        tx_stretch <= $urandom_range(20, 200);
        tx_quiet <= $urandom_range(0, 2) == 0;
      end else begin
        tx_stretch <= tx_stretch - 1;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          rx_if.valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          it = byte_queue.pop_front();
          rx_if.valid <= 1'b1;
          rx_if.data_byte <= it.data_byte;
          rx_if.frame_start <= it.frame_start;
          if (!tx_quiet && byte_queue.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
            tx_gap <= $urandom_range(1, 11);
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    reading_t e;
    if (rst) begin
      res_if.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        readings_seen <= readings_seen + 1;
        if (reading_queue.size() == 0) begin
          report_mismatch("unexpected reading", 1, 0);
        end else begin
          e = reading_queue.pop_front();
          if (res_if.temperature_centi !== e.temperature_centi)
            report_mismatch("temperature_centi", int'(res_if.temperature_centi),
                            int'(e.temperature_centi));
          if (res_if.humidity_centi !== e.humidity_centi)
            report_mismatch("humidity_centi", int'(res_if.humidity_centi),
                            int'(e.humidity_centi));
          if (res_if.temperature_raw !== e.temperature_raw)
            report_mismatch("temperature_raw", int'(res_if.temperature_raw),
                            int'(e.temperature_raw));
          if (res_if.humidity_raw !== e.humidity_raw)
            report_mismatch("humidity_raw", int'(res_if.humidity_raw),
                            int'(e.humidity_raw));
          if (res_if.temperature_check_ok !== e.temperature_check_ok)
            report_mismatch("temperature_check_ok", int'(res_if.temperature_check_ok),
                            int'(e.temperature_check_ok));
          if (res_if.humidity_check_ok !== e.humidity_check_ok)
            report_mismatch("humidity_check_ok", int'(res_if.humidity_check_ok),
                            int'(e.humidity_check_ok));
          if (res_if.reading_valid !== e.reading_valid)
            report_mismatch("reading_valid", int'(res_if.reading_valid),
                            int'(e.reading_valid));
        end
      end
      if (rx_stretch == 0) begin
        rx_stretch <= $urandom_range(20, 200);
        rx_quiet <= $urandom_range(0, 2) == 0;
      end else begin
        rx_stretch <= rx_stretch - 1;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (!rx_quiet && byte_queue.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
          rx_gap <= $urandom_range(1, 11);
      end
    end
  end

  // long result stall so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && readings_seen >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no item accepted", idle_cycles);
      $display("humidity_temp_frame_decoder_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
